@@ hw/rtl/tpfm_pkg.sv @@
// Shared types and constants for the thermal process fault monitor.
`default_nettype none

package tpfm_pkg;

  // Fixed widths of the configuration registers.
  localparam int LIMIT_WIDTH     = 20;
  localparam int WLEN_WIDTH      = 16;
  localparam int THRESH_WIDTH    = 17;
  localparam int FULL_PWR_WIDTH  = 16;

  // Configuration bus geometry.
  localparam int APB_DATA_WIDTH  = 32;
  localparam int APB_ADDR_WIDTH  = 5;
  localparam int REG_IDX_WIDTH   = 3;

  // Register index codes, at byte address 4 * index.
  localparam logic [REG_IDX_WIDTH-1:0] REG_FROZEN_LIMIT        = 3'd0;
  localparam logic [REG_IDX_WIDTH-1:0] REG_WINDOW_LENGTH       = 3'd1;
  localparam logic [REG_IDX_WIDTH-1:0] REG_RISE_THRESHOLD      = 3'd2;
  localparam logic [REG_IDX_WIDTH-1:0] REG_INVERSION_MARGIN    = 3'd3;
  localparam logic [REG_IDX_WIDTH-1:0] REG_FLAT_RISE_THRESHOLD = 3'd4;
  localparam logic [REG_IDX_WIDTH-1:0] REG_FULL_POWER_MIN      = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [LIMIT_WIDTH-1:0]    FROZEN_LIMIT_RST        = 20'd3000;
  localparam logic [WLEN_WIDTH-1:0]     WINDOW_LENGTH_RST       = 16'd600;
  localparam logic [THRESH_WIDTH-1:0]   RISE_THRESHOLD_RST      = 17'd200;
  localparam logic [THRESH_WIDTH-1:0]   INVERSION_MARGIN_RST    = 17'd500;
  localparam logic [THRESH_WIDTH-1:0]   FLAT_RISE_THRESHOLD_RST = 17'd100;
  localparam logic [FULL_PWR_WIDTH-1:0] FULL_POWER_MIN_RST      = 16'd900;

  // Settings used by the window checks.
  typedef struct packed {
    logic [WLEN_WIDTH-1:0]     window_length;
    logic [THRESH_WIDTH-1:0]   rise_threshold;
    logic [THRESH_WIDTH-1:0]   inversion_margin;
    logic [THRESH_WIDTH-1:0]   flat_rise_threshold;
    logic [FULL_PWR_WIDTH-1:0] full_power_min;
  } window_cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/tpfm_ifs.sv @@
// Valid/ready channel interfaces for the tick words and the fault flag words.
`default_nettype none

interface tpfm_tick_if #(
  parameter int TEMP_WIDTH  = 18,
  parameter int POWER_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [TEMP_WIDTH-1:0]  filament_temp;
  logic                          filament_valid;
  logic signed [TEMP_WIDTH-1:0]  heat_temp;
  logic                          heat_valid;
  logic [POWER_WIDTH-1:0]        heater_power;
  logic                          heating_on;

  modport source (
    output valid, filament_temp, filament_valid, heat_temp, heat_valid,
           heater_power, heating_on,
    input  ready
  );
  modport sink (
    input  valid, filament_temp, filament_valid, heat_temp, heat_valid,
           heater_power, heating_on,
    output ready
  );
endinterface

interface tpfm_flags_if;
  logic valid;
  logic ready;
  logic filament_frozen;
  logic heat_frozen;
  logic zones_inverted;
  logic power_without_rise;
  logic fault_any;

  modport source (
    output valid, filament_frozen, heat_frozen, zones_inverted,
           power_without_rise, fault_any,
    input  ready
  );
  modport sink (
    input  valid, filament_frozen, heat_frozen, zones_inverted,
           power_without_rise, fault_any,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/tpfm_frozen.sv @@
// Per-sensor frozen reading detector with a saturating repeat counter.
`default_nettype none

module tpfm_frozen #(
  parameter int TEMP_WIDTH         = 18,
  parameter int FROZEN_COUNT_WIDTH = 20
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                step,
  input  wire logic [TEMP_WIDTH-1:0]               reading,
  input  wire logic                                reading_valid,
  input  wire logic [tpfm_pkg::LIMIT_WIDTH-1:0]    frozen_limit,
  output logic                                     frozen
);
  import tpfm_pkg::*;

  localparam int CW = (FROZEN_COUNT_WIDTH > LIMIT_WIDTH) ? FROZEN_COUNT_WIDTH
                                                          : LIMIT_WIDTH;

  logic [TEMP_WIDTH-1:0]         last_reading;
  logic [FROZEN_COUNT_WIDTH-1:0] same_count;
  logic                          track_seeded;
  logic                          frozen_reported;

  logic                          same;
  logic [FROZEN_COUNT_WIDTH-1:0] count_inc;

  // The repeat count stops at all ones; the limit test uses the bumped count.
  always_comb begin
    same      = (reading == last_reading);
    count_inc = (same_count == '1) ? same_count : same_count + 1'b1;
    frozen    = reading_valid && track_seeded && same && !frozen_reported &&
                (CW'(count_inc) >= CW'(frozen_limit));
  end

  // History update on each valid reading.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_reading    <= '0;
      same_count      <= '0;
      track_seeded    <= 1'b0;
      frozen_reported <= 1'b0;
    end else if (step && reading_valid) begin
      if (!track_seeded) begin
        last_reading <= reading;
        same_count   <= '0;
        track_seeded <= 1'b1;
      end else if (!same) begin
        last_reading    <= reading;
        same_count      <= '0;
        frozen_reported <= 1'b0;
      end else begin
        same_count <= count_inc;
        if (frozen) begin
          frozen_reported <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tpfm_window.sv @@
// Windowed zone inversion and power-without-rise checks.
`default_nettype none

module tpfm_window #(
  parameter int TEMP_WIDTH         = 18,
  parameter int POWER_WIDTH        = 16,
  parameter int WINDOW_COUNT_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          step,
  input  wire logic signed [TEMP_WIDTH-1:0]  filament_temp,
  input  wire logic                          filament_valid,
  input  wire logic signed [TEMP_WIDTH-1:0]  heat_temp,
  input  wire logic                          heat_valid,
  input  wire logic [POWER_WIDTH-1:0]        heater_power,
  input  wire logic                          heating_on,
  input  wire tpfm_pkg::window_cfg_t         cfg,
  output logic                               zones_inverted,
  output logic                               power_without_rise
);
  import tpfm_pkg::*;

  localparam int SW  = ((TEMP_WIDTH > THRESH_WIDTH) ? TEMP_WIDTH : THRESH_WIDTH) + 2;
  localparam int WCW = (WINDOW_COUNT_WIDTH > WLEN_WIDTH) ? WINDOW_COUNT_WIDTH
                                                          : WLEN_WIDTH;
  localparam int PW  = (POWER_WIDTH > FULL_PWR_WIDTH) ? POWER_WIDTH : FULL_PWR_WIDTH;

  logic [WINDOW_COUNT_WIDTH-1:0] window_count;
  logic signed [TEMP_WIDTH-1:0]  filament_start;
  logic signed [TEMP_WIDTH-1:0]  heat_start;
  logic                          window_seeded;
  logic                          powered_whole_window;
  logic                          heated_in_window;

  logic                          both_ok;
  logic [WINDOW_COUNT_WIDTH-1:0] count_inc;
  logic                          window_end;
  logic                          powered_next;
  logic                          heated_next;
  logic signed [SW-1:0]          fv, hv, fs, hs;
  logic signed [SW-1:0]          rise_s, margin_s, flat_s;
  logic                          fil_rose;
  logic                          no_lead;
  logic                          heat_flat;

  // Tracking flags include this tick before the window end is judged.
  always_comb begin
    both_ok      = filament_valid && heat_valid;
    count_inc    = (window_count == '1) ? window_count : window_count + 1'b1;
    window_end   = both_ok && window_seeded &&
                   (WCW'(count_inc) >= WCW'(cfg.window_length));
    powered_next = powered_whole_window && heating_on &&
                   (PW'(heater_power) >= PW'(cfg.full_power_min));
    heated_next  = heated_in_window || (heating_on && (heater_power != '0));
  end

  // Exact signed differences against zero-extended thresholds.
  always_comb begin
    fv       = SW'(filament_temp);
    hv       = SW'(heat_temp);
    fs       = SW'(filament_start);
    hs       = SW'(heat_start);
    rise_s   = SW'(signed'({1'b0, cfg.rise_threshold}));
    margin_s = SW'(signed'({1'b0, cfg.inversion_margin}));
    flat_s   = SW'(signed'({1'b0, cfg.flat_rise_threshold}));
    fil_rose = (fv - fs) >= rise_s;
    no_lead  = hv < (fv + margin_s);
    heat_flat = (hv - hs) < flat_s;
    zones_inverted     = window_end && heated_next && fil_rose && no_lead;
    power_without_rise = window_end && powered_next && heat_flat;
  end

  // Window seeding, tracking and restart.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_count         <= '0;
      filament_start       <= '0;
      heat_start           <= '0;
      window_seeded        <= 1'b0;
      powered_whole_window <= 1'b1;
      heated_in_window     <= 1'b0;
    end else if (step) begin
      if (!both_ok) begin
        window_seeded <= 1'b0;
      end else if (!window_seeded) begin
        filament_start       <= filament_temp;
        heat_start           <= heat_temp;
        window_count         <= '0;
        powered_whole_window <= 1'b1;
        heated_in_window     <= 1'b0;
        window_seeded        <= 1'b1;
      end else begin
        powered_whole_window <= powered_next;
        heated_in_window     <= heated_next;
        window_count         <= count_inc;
        if (window_end) begin
          window_seeded <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/thermal_process_fault_monitor_core.sv @@
// Top level of the thermal process fault monitor: channels, registers, checks.
`default_nettype none

// One tick word is accepted per clock while the result register is not
// stalled, and each yields exactly one flag word. A word is captured in an
// input register, evaluated combinationally against the frozen and window
// state, and the flags land in a result register, so a flag word is presented
// once its tick word has passed the input register and the result register.
// Throughput is one word per cycle while the result register is not stalled;
// a stalled result register holds the input register, which then stops
// acceptance. Settings are written over the APB port at byte address 4 * index
// (frozen_limit, window_length, rise_threshold, inversion_margin,
// flat_rise_threshold, full_power_min) by the user only while no word is in flight; the block does not enforce this.
module thermal_process_fault_monitor_core #(
  parameter int TEMP_WIDTH         = 18,
  parameter int POWER_WIDTH        = 16,
  parameter int FROZEN_COUNT_WIDTH = 20,
  parameter int WINDOW_COUNT_WIDTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  tpfm_tick_if.sink                                  tick,
  tpfm_flags_if.source                               flags,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [tpfm_pkg::APB_ADDR_WIDTH-1:0]   paddr,
  input  wire logic [tpfm_pkg::APB_DATA_WIDTH-1:0]   pwdata,
  output logic [tpfm_pkg::APB_DATA_WIDTH-1:0]        prdata,
  output logic                                       pready
);
  import tpfm_pkg::*;

  // Configuration registers.
  logic [LIMIT_WIDTH-1:0]    frozen_limit;
  window_cfg_t               wcfg;
  logic [REG_IDX_WIDTH-1:0]  reg_idx;
  logic                      cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[APB_ADDR_WIDTH-1:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frozen_limit             <= FROZEN_LIMIT_RST;
      wcfg.window_length       <= WINDOW_LENGTH_RST;
      wcfg.rise_threshold      <= RISE_THRESHOLD_RST;
      wcfg.inversion_margin    <= INVERSION_MARGIN_RST;
      wcfg.flat_rise_threshold <= FLAT_RISE_THRESHOLD_RST;
      wcfg.full_power_min      <= FULL_POWER_MIN_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_FROZEN_LIMIT:        frozen_limit <= pwdata[LIMIT_WIDTH-1:0];
        REG_WINDOW_LENGTH:       wcfg.window_length <= pwdata[WLEN_WIDTH-1:0];
        REG_RISE_THRESHOLD:      wcfg.rise_threshold <= pwdata[THRESH_WIDTH-1:0];
        REG_INVERSION_MARGIN:    wcfg.inversion_margin <= pwdata[THRESH_WIDTH-1:0];
        REG_FLAT_RISE_THRESHOLD: wcfg.flat_rise_threshold <= pwdata[THRESH_WIDTH-1:0];
        REG_FULL_POWER_MIN:      wcfg.full_power_min <= pwdata[FULL_PWR_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (reg_idx)
      REG_FROZEN_LIMIT:        prdata = APB_DATA_WIDTH'(frozen_limit);
      REG_WINDOW_LENGTH:       prdata = APB_DATA_WIDTH'(wcfg.window_length);
      REG_RISE_THRESHOLD:      prdata = APB_DATA_WIDTH'(wcfg.rise_threshold);
      REG_INVERSION_MARGIN:    prdata = APB_DATA_WIDTH'(wcfg.inversion_margin);
      REG_FLAT_RISE_THRESHOLD: prdata = APB_DATA_WIDTH'(wcfg.flat_rise_threshold);
      REG_FULL_POWER_MIN:      prdata = APB_DATA_WIDTH'(wcfg.full_power_min);
      default:                 prdata = '0;
    endcase
  end

  // Input register and result register handshake.
  logic                          in_full;
  logic                          out_full;
  logic                          advance;
  logic                          accept;
  logic signed [TEMP_WIDTH-1:0]  in_fil;
  logic                          in_fil_ok;
  logic signed [TEMP_WIDTH-1:0]  in_heat;
  logic                          in_heat_ok;
  logic [POWER_WIDTH-1:0]        in_power;
  logic                          in_heating;

  assign advance    = in_full && (!out_full || flags.ready);
  assign tick.ready = !in_full || advance;
  assign accept     = tick.valid && tick.ready;
  assign flags.valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_fil     <= tick.filament_temp;
      in_fil_ok  <= tick.filament_valid;
      in_heat    <= tick.heat_temp;
      in_heat_ok <= tick.heat_valid;
      in_power   <= tick.heater_power;
      in_heating <= tick.heating_on;
    end
  end

  // Check units.
  logic fil_frozen;
  logic heat_frozen;
  logic inverted;
  logic no_rise;

  tpfm_frozen #(
    .TEMP_WIDTH         (TEMP_WIDTH),
    .FROZEN_COUNT_WIDTH (FROZEN_COUNT_WIDTH)
  ) u_frozen_fil (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .reading       (in_fil),
    .reading_valid (in_fil_ok),
    .frozen_limit  (frozen_limit),
    .frozen        (fil_frozen)
  );

  tpfm_frozen #(
    .TEMP_WIDTH         (TEMP_WIDTH),
    .FROZEN_COUNT_WIDTH (FROZEN_COUNT_WIDTH)
  ) u_frozen_heat (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .reading       (in_heat),
    .reading_valid (in_heat_ok),
    .frozen_limit  (frozen_limit),
    .frozen        (heat_frozen)
  );

  tpfm_window #(
    .TEMP_WIDTH         (TEMP_WIDTH),
    .POWER_WIDTH        (POWER_WIDTH),
    .WINDOW_COUNT_WIDTH (WINDOW_COUNT_WIDTH)
  ) u_window (
    .clk                (clk),
    .rst                (rst),
    .step               (advance),
    .filament_temp      (in_fil),
    .filament_valid     (in_fil_ok),
    .heat_temp          (in_heat),
    .heat_valid         (in_heat_ok),
    .heater_power       (in_power),
    .heating_on         (in_heating),
    .cfg                (wcfg),
    .zones_inverted     (inverted),
    .power_without_rise (no_rise)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= 1'b1;
    end else if (flags.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      flags.filament_frozen    <= fil_frozen;
      flags.heat_frozen        <= heat_frozen;
      flags.zones_inverted     <= inverted;
      flags.power_without_rise <= no_rise;
      flags.fault_any          <= fil_frozen || heat_frozen || inverted || no_rise;
    end
  end

endmodule

`default_nettype wire
